// ----- src/dsa_pkg.sv -----
// Shared types, constants and saturating fixed-point helpers for the damped spin advance core.
`default_nettype none
package dsa_pkg;

	// Internal format: signed Q31.32 with symmetric saturation.
	typedef logic signed [63:0] fix_t;

	localparam fix_t SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam fix_t SAT_NEG = 64'sh8000_0000_0000_0001;
	localparam fix_t FIX_MIN = 64'sh8000_0000_0000_0000;
	localparam fix_t Q_ONE   = 64'sh0000_0001_0000_0000;

	typedef enum logic [0:0] {
		REG_DAMPING_GAIN = 1'b0,
		REG_STEP_SIZE    = 1'b1
	} reg_idx_t;

	function automatic fix_t sat_add(fix_t a, fix_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(SAT_MAX))
			return SAT_MAX;
		else if (s < 65'(SAT_NEG))
			return SAT_NEG;
		return fix_t'(s[63:0]);
	endfunction

	function automatic fix_t sat_sub(fix_t a, fix_t b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'(SAT_MAX))
			return SAT_MAX;
		else if (s < 65'(SAT_NEG))
			return SAT_NEG;
		return fix_t'(s[63:0]);
	endfunction

	// Divide by 2^k, truncating toward zero.
	function automatic fix_t div_pow2(fix_t x, int k);
		fix_t bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

	// Scale a sign-extended input into Q31.32; most negative code folds to -SAT_MAX.
	function automatic fix_t conv_in(fix_t x, int up, int dn);
		fix_t r;
		r = div_pow2(x <<< up, dn);
		if (r == FIX_MIN)
			return SAT_NEG;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/dsa_if.sv -----
// Request channel interfaces: spin/field input and advanced spin output.
`default_nettype none
interface dsa_in_if #(
	parameter int SPIN_BITS  = 32,
	parameter int FIELD_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [SPIN_BITS-1:0]  spin_x;
	logic signed [SPIN_BITS-1:0]  spin_y;
	logic signed [SPIN_BITS-1:0]  spin_z;
	logic signed [FIELD_BITS-1:0] field_x;
	logic signed [FIELD_BITS-1:0] field_y;
	logic signed [FIELD_BITS-1:0] field_z;
	logic                         last_spin;

	modport source (output valid, spin_x, spin_y, spin_z, field_x, field_y, field_z, last_spin,
		input ready);
	modport sink (input valid, spin_x, spin_y, spin_z, field_x, field_y, field_z, last_spin,
		output ready);
endinterface

interface dsa_out_if #(
	parameter int SPIN_BITS = 32
);
	logic                        valid;
	logic                        ready;
	logic signed [SPIN_BITS-1:0] new_spin_x;
	logic signed [SPIN_BITS-1:0] new_spin_y;
	logic signed [SPIN_BITS-1:0] new_spin_z;
	logic                        sweep_end;

	modport source (output valid, new_spin_x, new_spin_y, new_spin_z, sweep_end, input ready);
	modport sink (input valid, new_spin_x, new_spin_y, new_spin_z, sweep_end, output ready);
endinterface
`default_nettype wire

// ----- src/dsa_mulq.sv -----
// Two-stage saturating Q31.32 multiplier built from four 32x32 partial products.
`default_nettype none
module dsa_mulq (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire dsa_pkg::fix_t a,
	input  wire dsa_pkg::fix_t b,
	output dsa_pkg::fix_t     p
);

	logic [63:0] ua, ub;
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic        neg_s1;
	logic [63:0] mid, hi, m;
	dsa_pkg::fix_t prod_nx, prod_s2;

	always_comb begin
		ua = a[63] ? 64'(64'sd0 - a) : 64'(a);
		ub = b[63] ? 64'(64'sd0 - b) : 64'(b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(ua[31:0]) * 64'(ub[31:0]);
			p01_s1 <= 64'(ua[31:0]) * 64'(ub[63:32]);
			p10_s1 <= 64'(ua[63:32]) * 64'(ub[31:0]);
			p11_s1 <= 64'(ua[63:32]) * 64'(ub[63:32]);
			neg_s1 <= a[63] ^ b[63];
		end
	end

	// Drop 32 fraction bits; anything above 63 magnitude bits saturates.
	always_comb begin
		mid = {32'd0, p00_s1[63:32]} + {32'd0, p01_s1[31:0]} + {32'd0, p10_s1[31:0]};
		hi  = p11_s1 + {32'd0, p01_s1[63:32]} + {32'd0, p10_s1[63:32]} + {32'd0, mid[63:32]};
		m   = {hi[31:0], mid[31:0]};
		if (hi[63:32] != 32'd0 || m[63])
			m = 64'(dsa_pkg::SAT_MAX);
		prod_nx = neg_s1 ? dsa_pkg::fix_t'(64'd0 - m) : dsa_pkg::fix_t'(m);
	end

	always_ff @(posedge clk) begin
		if (en)
			prod_s2 <= prod_nx;
	end

	assign p = prod_s2;

endmodule
`default_nettype wire

// ----- src/dsa_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: |n| * 2^32 / d.
`default_nettype none
module dsa_div (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire dsa_pkg::fix_t n,
	input  wire logic [63:0]   d,
	output logic [63:0]        mag,
	output logic               neg
);

	localparam int STEPS = 64;

	logic [63:0] un;
	logic [63:0] rem_q [0:STEPS];
	logic [31:0] lo_q  [0:STEPS];
	logic [63:0] quo_q [0:STEPS];
	logic [63:0] den_q [0:STEPS];
	logic        neg_q [0:STEPS];
	logic        sat_q [0:STEPS];
	logic [63:0] rem_nx [1:STEPS];
	logic [63:0] quo_nx [1:STEPS];

	assign un = n[63] ? 64'(64'sd0 - n) : 64'(n);

	always_comb begin
		logic [63:0] sh;
		for (int k = 1; k <= STEPS; k++) begin
			sh = {rem_q[k-1][62:0], lo_q[k-1][31]};
			if (rem_q[k-1][63] || sh >= den_q[k-1]) begin
				rem_nx[k] = sh - den_q[k-1];
				quo_nx[k] = {quo_q[k-1][62:0], 1'b1};
			end else begin
				rem_nx[k] = sh;
				quo_nx[k] = {quo_q[k-1][62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= {32'd0, un[63:32]};
			lo_q[0]  <= un[31:0];
			quo_q[0] <= '0;
			den_q[0] <= d;
			neg_q[0] <= n[63];
			sat_q[0] <= {32'd0, un[63:32]} >= d;
			for (int k = 1; k <= STEPS; k++) begin
				rem_q[k] <= rem_nx[k];
				lo_q[k]  <= {lo_q[k-1][30:0], 1'b0};
				quo_q[k] <= quo_nx[k];
				den_q[k] <= den_q[k-1];
				neg_q[k] <= neg_q[k-1];
				sat_q[k] <= sat_q[k-1];
			end
		end
	end

	assign mag = (sat_q[STEPS] || quo_q[STEPS][63]) ? 64'(dsa_pkg::SAT_MAX) : quo_q[STEPS];
	assign neg = neg_q[STEPS];

endmodule
`default_nettype wire

// ----- src/damped_spin_advance_core.sv -----
// Top level: pipelined damped, norm-preserving spin precession step.
// Throughput: one request per cycle; the 65-stage divider and the 2-stage multipliers are
// fully pipelined, and the whole pipe holds while a finished result waits downstream.
// Reset: arst_n clears all valid bits, damping_gain to 1.0 and step_size to 0.
`default_nettype none
module damped_spin_advance_core #(
	parameter int SPIN_BITS  = 32,
	parameter int FIELD_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire dsa_pkg::reg_idx_t cfg_idx,
	input  wire logic [31:0]       cfg_wdata,
	dsa_in_if.sink                 spin_in,
	dsa_out_if.source              spin_out
);

	// Stage map (register stage after acceptance):
	//  1 input conversion | 2-3 f x s products | 4 negated cross | 5-6 torque t
	//  7-8 t products | 9-10 |t|^2, s.t, t x s | 11 |t|^2/4 | 12-13 second products
	//  14 den, corr, s + (t x s)dt | 15 corr/2 | 16-17 times dt^2 | 18 numerator
	//  19-83 divider | 84 output register
	localparam int LAT = 84;

	localparam int SP_FRAC = SPIN_BITS - 3;
	localparam int SP_UP   = (SP_FRAC <= 32) ? 32 - SP_FRAC : 0;
	localparam int SP_DN   = (SP_FRAC > 32) ? SP_FRAC - 32 : 0;
	localparam int FD_FRAC = FIELD_BITS / 2;
	localparam int FD_UP   = (FD_FRAC <= 32) ? 32 - FD_FRAC : 0;
	localparam int FD_DN   = (FD_FRAC > 32) ? FD_FRAC - 32 : 0;
	// Output rescale: the reverse direction of the spin input scaling.
	localparam logic [63:0] OUT_LIM = 64'(dsa_pkg::SAT_MAX) >> SP_DN;
	localparam logic [63:0] POS_MAX = (64'd1 << (SPIN_BITS - 1)) - 64'd1;
	localparam logic [63:0] NEG_MAX = 64'd1 << (SPIN_BITS - 1);

	// Global advance: the pipe moves unless a finished result is held.
	logic en;
	logic [LAT:1] vld_q;
	logic [LAT-1:1] last_q;

	assign en            = !vld_q[LAT] || spin_out.ready;
	assign spin_in.ready = en;
	assign spin_out.valid = vld_q[LAT];

	// Configuration registers
	logic [31:0] gain_q, step_q;
	dsa_pkg::fix_t alpha, dt, dt2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 32'h0100_0000;
			step_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dsa_pkg::REG_DAMPING_GAIN: gain_q <= cfg_wdata;
				dsa_pkg::REG_STEP_SIZE:    step_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign alpha = dsa_pkg::fix_t'({24'd0, gain_q, 8'd0});
	assign dt    = dsa_pkg::fix_t'({16'd0, step_q, 16'd0});

	// dt^2 from the static config; settles well before any request reaches its use.
	dsa_mulq u_dt2 (.clk(clk), .en(1'b1), .a(dt), .b(dt), .p(dt2));

	// Valid and marker chains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-1:1], spin_in.valid};
	end

	// ---- Stage 1: input conversion to Q31.32 ----
	dsa_pkg::fix_t spin_dly_q [1:13][0:2];
	dsa_pkg::fix_t field_s1 [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[LAT-2:1], spin_in.last_spin};
			spin_dly_q[1][0] <= dsa_pkg::conv_in(dsa_pkg::fix_t'(spin_in.spin_x), SP_UP, SP_DN);
			spin_dly_q[1][1] <= dsa_pkg::conv_in(dsa_pkg::fix_t'(spin_in.spin_y), SP_UP, SP_DN);
			spin_dly_q[1][2] <= dsa_pkg::conv_in(dsa_pkg::fix_t'(spin_in.spin_z), SP_UP, SP_DN);
			field_s1[0] <= dsa_pkg::conv_in(dsa_pkg::fix_t'(spin_in.field_x), FD_UP, FD_DN);
			field_s1[1] <= dsa_pkg::conv_in(dsa_pkg::fix_t'(spin_in.field_y), FD_UP, FD_DN);
			field_s1[2] <= dsa_pkg::conv_in(dsa_pkg::fix_t'(spin_in.field_z), FD_UP, FD_DN);
			for (int k = 2; k <= 13; k++)
				spin_dly_q[k] <= spin_dly_q[k-1];
		end
	end

	// Per-component datapath; J and K are the other two axes in cyclic order.
	dsa_pkg::fix_t fs_a [0:2], fs_b [0:2], negd_s4 [0:2], torq [0:2];
	dsa_pkg::fix_t tt [0:2], st [0:2], cpa [0:2], cpb [0:2];
	dsa_pkg::fix_t t_dly_q [7:11][0:2];
	dsa_pkg::fix_t cp_s9 [0:2], cp_s10 [0:2], cp_s11 [0:2];
	dsa_pkg::fix_t te [0:2], sf [0:2], cd [0:2];
	dsa_pkg::fix_t corr_s14 [0:2], g1_s14 [0:2], corrh_s15 [0:2], g1_s15 [0:2];
	dsa_pkg::fix_t g1_s16 [0:2], g1_s17 [0:2], cdt [0:2], g_s18 [0:2];
	logic [63:0] dmag [0:2];
	logic        dneg [0:2];
	logic [SPIN_BITS-1:0] res [0:2];
	logic [SPIN_BITS-1:0] res_q [0:2];

	dsa_pkg::fix_t fm2ab_s9, tt2_s9, enab_s9, st2_s9;
	dsa_pkg::fix_t fm2_s10, en_s10, fm2q_s11, fm2_s11, en_s11, mden;
	dsa_pkg::fix_t den_s14, den_s15, den_s16, den_s17, den_s18;
	logic sweep_q;

	for (genvar i = 0; i < 3; i++) begin : g_axis
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;

		// Stages 2-3: f x s partial terms
		dsa_mulq u_fsa (.clk(clk), .en(en), .a(field_s1[J]), .b(spin_dly_q[1][K]), .p(fs_a[i]));
		dsa_mulq u_fsb (.clk(clk), .en(en), .a(field_s1[K]), .b(spin_dly_q[1][J]), .p(fs_b[i]));

		// Stage 4: -(f x s), so the torque multiply carries the minus sign
		always_ff @(posedge clk) begin
			if (en)
				negd_s4[i] <= dsa_pkg::sat_sub(fs_b[i], fs_a[i]);
		end

		// Stages 5-6: torque
		dsa_mulq u_tq (.clk(clk), .en(en), .a(alpha), .b(negd_s4[i]), .p(torq[i]));

		// Stages 7-8: |t|^2 terms, s.t terms, t x s terms
		dsa_mulq u_tt (.clk(clk), .en(en), .a(torq[i]), .b(torq[i]), .p(tt[i]));
		dsa_mulq u_st (.clk(clk), .en(en), .a(spin_dly_q[6][i]), .b(torq[i]), .p(st[i]));
		dsa_mulq u_ca (.clk(clk), .en(en), .a(torq[J]), .b(spin_dly_q[6][K]), .p(cpa[i]));
		dsa_mulq u_cb (.clk(clk), .en(en), .a(torq[K]), .b(spin_dly_q[6][J]), .p(cpb[i]));

		always_ff @(posedge clk) begin
			if (en) begin
				cp_s9[i]  <= dsa_pkg::sat_sub(cpa[i], cpb[i]);
				cp_s10[i] <= cp_s9[i];
				cp_s11[i] <= cp_s10[i];
			end
		end

		// Stages 12-13
		dsa_mulq u_te (.clk(clk), .en(en), .a(t_dly_q[11][i]), .b(en_s11), .p(te[i]));
		dsa_mulq u_sf (.clk(clk), .en(en), .a(spin_dly_q[11][i]), .b(fm2_s11), .p(sf[i]));
		dsa_mulq u_cd (.clk(clk), .en(en), .a(cp_s11[i]), .b(dt), .p(cd[i]));

		// Stages 14-15: second-order correction and first-order sum
		always_ff @(posedge clk) begin
			if (en) begin
				corr_s14[i]  <= dsa_pkg::sat_sub(te[i], dsa_pkg::div_pow2(sf[i], 1));
				g1_s14[i]    <= dsa_pkg::sat_add(spin_dly_q[13][i], cd[i]);
				corrh_s15[i] <= dsa_pkg::div_pow2(corr_s14[i], 1);
				g1_s15[i]    <= g1_s14[i];
				g1_s16[i]    <= g1_s15[i];
				g1_s17[i]    <= g1_s16[i];
			end
		end

		// Stages 16-17: correction times dt^2
		dsa_mulq u_cdt (.clk(clk), .en(en), .a(corrh_s15[i]), .b(dt2), .p(cdt[i]));

		// Stage 18: numerator
		always_ff @(posedge clk) begin
			if (en)
				g_s18[i] <= dsa_pkg::sat_add(g1_s17[i], cdt[i]);
		end

		// Stages 19-83: normalization divide
		dsa_div u_div (
			.clk(clk), .en(en), .n(g_s18[i]), .d(64'(den_s18)),
			.mag(dmag[i]), .neg(dneg[i])
		);

		// Back to the spin format: rescale the magnitude, clamp, apply sign.
		always_comb begin
			logic [63:0] sm, cap;
			if (SP_DN == 0)
				sm = dmag[i] >> SP_UP;
			else if (dmag[i] > OUT_LIM)
				sm = 64'(dsa_pkg::SAT_MAX);
			else
				sm = dmag[i] << SP_DN;
			if (dneg[i])
				cap = (sm > NEG_MAX) ? NEG_MAX : sm;
			else
				cap = (sm > POS_MAX) ? POS_MAX : sm;
			cap = dneg[i] ? 64'd0 - cap : cap;
			res[i] = cap[SPIN_BITS-1:0];
		end

		always_ff @(posedge clk) begin
			if (en)
				res_q[i] <= res[i];
		end
	end

	// Torque delay to stage 11; scalar sums
	always_ff @(posedge clk) begin
		if (en) begin
			t_dly_q[7] <= torq;
			for (int k = 8; k <= 11; k++)
				t_dly_q[k] <= t_dly_q[k-1];
			fm2ab_s9 <= dsa_pkg::sat_add(tt[0], tt[1]);
			tt2_s9   <= tt[2];
			enab_s9  <= dsa_pkg::sat_add(st[0], st[1]);
			st2_s9   <= st[2];
			fm2_s10  <= dsa_pkg::sat_add(fm2ab_s9, tt2_s9);
			en_s10   <= dsa_pkg::sat_add(enab_s9, st2_s9);
			fm2q_s11 <= dsa_pkg::div_pow2(fm2_s10, 2);
			fm2_s11  <= fm2_s10;
			en_s11   <= en_s10;
			den_s14  <= dsa_pkg::sat_add(dsa_pkg::Q_ONE, mden);
			den_s15  <= den_s14;
			den_s16  <= den_s15;
			den_s17  <= den_s16;
			den_s18  <= den_s17;
			sweep_q  <= last_q[LAT-1];
		end
	end

	// Stages 12-13: denominator term |t|^2/4 * dt^2
	dsa_mulq u_den (.clk(clk), .en(en), .a(fm2q_s11), .b(dt2), .p(mden));

	assign spin_out.new_spin_x = res_q[0];
	assign spin_out.new_spin_y = res_q[1];
	assign spin_out.new_spin_z = res_q[2];
	assign spin_out.sweep_end  = sweep_q;

`ifndef NO_ASSERTIONS
	// A held result must freeze the whole pipe, input side included.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		spin_out.valid && !spin_out.ready |-> !spin_in.ready)
		else $error("input accepted while result stalled");

	// An accepted request enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		spin_in.valid && spin_in.ready |=> vld_q[1])
		else $error("accepted request lost at stage 1");

	// The normalizing denominator never drops below 1.0.
	a_den_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[14] |-> den_s14 >= dsa_pkg::Q_ONE)
		else $error("denominator below one");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_damped_spin_advance_core.sv -----
// Self-checking bench for the damped spin advance core: predicted spins versus pipeline output.
`timescale 1ns / 1ps
module tb_damped_spin_advance_core;

	localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] sx, sy, sz, fx, fy, fz;
		logic        last;
	} spin_req_t;

	typedef struct packed {
		logic [31:0] nx, ny, nz;
		logic        eos;
	} spin_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	dsa_pkg::reg_idx_t cfg_idx = dsa_pkg::REG_DAMPING_GAIN;
	logic [31:0] cfg_wdata = '0;

	dsa_in_if  #(.SPIN_BITS(32), .FIELD_BITS(32)) spin_in ();
	dsa_out_if #(.SPIN_BITS(32)) spin_out ();

	damped_spin_advance_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .spin_in(spin_in.sink), .spin_out(spin_out.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor's own copy of the two registers.
	logic [31:0] alpha_q = 32'h0100_0000;
	logic [31:0] dt_q = 32'h0;

	spin_req_t pending_reqs[$];
	spin_res_t expected_spins[$];
	int mismatches = 0;
	int results_seen = 0;
	int hold_cycles = 0;
	bit holdoff_on = 1'b0;

	// ---------------- fixed-point predictor (Q31.32, symmetric saturation) -------------
	function automatic longint s_add(longint a, longint b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(SMAX)) return SMAX;
		if (s < -65'(SMAX)) return -SMAX;
		return longint'(s[63:0]);
	endfunction

	function automatic longint s_sub(longint a, longint b);
		return s_add(a, -b);
	endfunction

	// Product of magnitudes, drop 32 fraction bits, saturate.
	function automatic longint fx_mul(longint a, longint b);
		logic [63:0] ua, ub;
		logic [127:0] p;
		logic [95:0] sh;
		bit neg;
		ua = a < 0 ? 64'(-a) : 64'(a);
		ub = b < 0 ? 64'(-b) : 64'(b);
		neg = (a < 0) != (b < 0);
		p = 128'(ua) * 128'(ub);
		sh = p[127:32];
		if (sh > 96'(SMAX)) return neg ? -SMAX : SMAX;
		return neg ? -longint'(sh[63:0]) : longint'(sh[63:0]);
	endfunction

	function automatic longint fx_div(longint n, longint d);
		logic [63:0] un;
		logic [127:0] q;
		bit neg;
		neg = n < 0;
		un = neg ? 64'(-n) : 64'(n);
		if ((un >> 32) >= 64'(d)) return neg ? -SMAX : SMAX;
		q = {32'b0, un, 32'b0} / 128'(d);
		if (q > 128'(SMAX)) q = 128'(SMAX);
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic longint spin_in_q(logic [31:0] raw);
		longint v;
		v = longint'($signed(raw)) * 8;
		return v;
	endfunction

	function automatic logic [31:0] spin_out_q(longint g);
		longint v;
		v = g / 8;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic spin_res_t advance_spin(spin_req_t r);
		longint s[3], f[3], t[3], cp[3], g[3];
		longint al, dt, dt2, fm2, en, den, corr;
		spin_res_t o;
		logic [31:0] n[3];
		s[0] = spin_in_q(r.sx); s[1] = spin_in_q(r.sy); s[2] = spin_in_q(r.sz);
		f[0] = longint'($signed(r.fx)) * 65536;
		f[1] = longint'($signed(r.fy)) * 65536;
		f[2] = longint'($signed(r.fz)) * 65536;
		al = longint'({32'b0, alpha_q}) * 256;
		dt = longint'({32'b0, dt_q}) * 65536;
		dt2 = fx_mul(dt, dt);
		t[0] = -fx_mul(al, s_sub(fx_mul(f[1], s[2]), fx_mul(f[2], s[1])));
		t[1] = -fx_mul(al, s_sub(fx_mul(f[2], s[0]), fx_mul(f[0], s[2])));
		t[2] = -fx_mul(al, s_sub(fx_mul(f[0], s[1]), fx_mul(f[1], s[0])));
		fm2 = s_add(s_add(fx_mul(t[0], t[0]), fx_mul(t[1], t[1])), fx_mul(t[2], t[2]));
		en = s_add(s_add(fx_mul(s[0], t[0]), fx_mul(s[1], t[1])), fx_mul(s[2], t[2]));
		cp[0] = s_sub(fx_mul(t[1], s[2]), fx_mul(t[2], s[1]));
		cp[1] = s_sub(fx_mul(t[2], s[0]), fx_mul(t[0], s[2]));
		cp[2] = s_sub(fx_mul(t[0], s[1]), fx_mul(t[1], s[0]));
		den = s_add(64'sh1_0000_0000, fx_mul(fm2 / 4, dt2));
		for (int i = 0; i < 3; i++) begin
			corr = s_sub(fx_mul(t[i], en), fx_mul(s[i], fm2) / 2);
			g[i] = s_add(s[i], fx_mul(cp[i], dt));
			g[i] = s_add(g[i], fx_mul(corr / 2, dt2));
			g[i] = fx_div(g[i], den);
			n[i] = spin_out_q(g[i]);
		end
		o.nx = n[0]; o.ny = n[1]; o.nz = n[2]; o.eos = r.last;
		return o;
	endfunction

	// ---------------- stimulus helpers ----------------
	// Mostly unit-scale spins and moderate fields, with occasional full-range words.
	function automatic logic [31:0] pick_spin();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_field();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
		endcase
	endfunction

	function automatic spin_req_t rand_req();
		spin_req_t r;
		r.sx = pick_spin(); r.sy = pick_spin(); r.sz = pick_spin();
		r.fx = pick_field(); r.fy = pick_field(); r.fz = pick_field();
		r.last = ($urandom_range(0, 15) == 0);
		return r;
	endfunction

	// ---------------- driver ----------------
	int src_gap = 0;
	spin_req_t cur_req;
	initial begin
		spin_in.valid = 1'b0;
		{spin_in.spin_x, spin_in.spin_y, spin_in.spin_z} = '0;
		{spin_in.field_x, spin_in.field_y, spin_in.field_z} = '0;
		spin_in.last_spin = 1'b0;
		spin_out.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (spin_in.valid && spin_in.ready) begin
			expected_spins.push_back(advance_spin(cur_req));
			src_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : 0;
		end
		if (!(spin_in.valid && !spin_in.ready)) begin
			if (src_gap > 0 || pending_reqs.size() == 0) begin
				if (src_gap > 0) src_gap--;
				spin_in.valid <= 1'b0;
			end else begin
				cur_req = pending_reqs.pop_front();
				spin_in.valid <= 1'b1;
				spin_in.spin_x <= cur_req.sx;
				spin_in.spin_y <= cur_req.sy;
				spin_in.spin_z <= cur_req.sz;
				spin_in.field_x <= cur_req.fx;
				spin_in.field_y <= cur_req.fy;
				spin_in.field_z <= cur_req.fz;
				spin_in.last_spin <= cur_req.last;
			end
		end
	end

	// Long receiver hold-off, counted in its own process.
	always @(posedge clk) begin
		if (holdoff_on) hold_cycles <= hold_cycles + 1;
	end

	// ---------------- monitor ----------------
	int sink_gap = 0;
	spin_res_t got, want;
	always @(posedge clk) begin
		if (spin_out.valid && spin_out.ready) begin
			got = '{spin_out.new_spin_x, spin_out.new_spin_y, spin_out.new_spin_z,
				spin_out.sweep_end};
			results_seen++;
			if (expected_spins.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected request result %p", got);
			end else begin
				want = expected_spins.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: expected %h %h %h %b got %h %h %h %b",
							results_seen, want.nx, want.ny, want.nz, want.eos,
							got.nx, got.ny, got.nz, got.eos);
				end
			end
			sink_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : 0;
		end
		if (holdoff_on) begin
			spin_out.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			spin_out.ready <= 1'b0;
		end else begin
			spin_out.ready <= 1'b1;
		end
	end

	// ---------------- sequencing ----------------
	task automatic write_reg(dsa_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		if (idx == dsa_pkg::REG_DAMPING_GAIN) alpha_q = val;
		else dt_q = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || spin_in.valid || expected_spins.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) pending_reqs.push_back(rand_req());
		drain();
	endtask

	spin_req_t d;
	logic [31:0] edge_words[4] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: dt = 0, so output is the spin itself (truncated), any field.
		for (int i = 0; i < 4; i++) begin
			d = '{edge_words[i], edge_words[(i+1)%4], edge_words[(i+2)%4],
				edge_words[(i+3)%4], edge_words[i], edge_words[(i+2)%4], i[0]};
			pending_reqs.push_back(d);
		end
		drain();

		// Unit spin along x, field along z (pure precession) and along x, then saturating extremes.
		write_reg(dsa_pkg::REG_STEP_SIZE, 32'h0000_1000);
		d = '{32'h2000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b1};
		pending_reqs.push_back(d);
		d = '{32'h2000_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b0};
		pending_reqs.push_back(d);
		for (int i = 0; i < 4; i++) begin
			d = '{edge_words[i], edge_words[(i+1)%4], edge_words[(i+3)%4],
				edge_words[(i+2)%4], edge_words[(i+1)%4], edge_words[i], ~i[0]};
			pending_reqs.push_back(d);
		end
		drain();
		write_reg(dsa_pkg::REG_DAMPING_GAIN, 32'hFFFF_FFFF);
		write_reg(dsa_pkg::REG_STEP_SIZE, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++) pending_reqs.push_back(rand_req());
		drain();
		write_reg(dsa_pkg::REG_DAMPING_GAIN, 32'h0);
		write_reg(dsa_pkg::REG_STEP_SIZE, 32'h0001_0000);
		for (int i = 0; i < 6; i++) pending_reqs.push_back(rand_req());
		drain();

		// Random phases over several settings.
		write_reg(dsa_pkg::REG_DAMPING_GAIN, 32'h0100_0000);
		write_reg(dsa_pkg::REG_STEP_SIZE, 32'h0000_0800);
		for (int i = 0; i < 300; i++) pending_reqs.push_back(rand_req());
		// Receiver stalls long enough for the pipe to fill and back up the input.
		holdoff_on = 1'b1;
		while (hold_cycles < 400) @(posedge clk);
		holdoff_on = 1'b0;
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(dsa_pkg::REG_DAMPING_GAIN, $urandom());
			write_reg(dsa_pkg::REG_STEP_SIZE,
				ph[0] ? $urandom() : $urandom_range(0, 32'h0002_0000));
			run_random(240);
		end

		$display("covered %0d results over extreme and random gain/step settings,",
			results_seen);
		$display("with random gaps on both sides and a long output stall");
		if (mismatches == 0 && expected_spins.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d left over", mismatches, expected_spins.size());
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end
endmodule
